// File: rtl/core/gtms_pkg.sv
// ----------------------------------------------------------------------------
// gtms_pkg
// Shared constants and codes for the gradient template match search block.
// ----------------------------------------------------------------------------
`default_nettype none

package gtms_pkg;

  // Default storage sizes
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;
  localparam int MAX_POINTS_DEF = 1024;

  // Stream payload widths (packed fields, padded to bytes)
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Input item kinds, carried on tuser
  localparam logic [1:0] MODE_PIXEL  = 2'd0;
  localparam logic [1:0] MODE_POINT  = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_RAD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd5;

  // Q1.15 unity
  localparam logic [15:0] Q_ONE = 16'h8000;

endpackage

`default_nettype wire

// File: rtl/core/gtms_ram.sv
// ----------------------------------------------------------------------------
// gtms_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gtms_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/gradient_template_match_search.sv
// ----------------------------------------------------------------------------
// gradient_template_match_search
// Shape based template matching over a stored gradient image: scores each
// candidate in a window by the mean normalised gradient dot product.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid/s_axis_tready    tdata fields, tuser mode
//  m_axis    out        m_axis_tvalid/m_axis_tready    tdata best, tuser found
//  cfg       in         cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
//  Pixel and point loads can stream back to back. Each template point on the
//  image with an edge runs through one shared 17x17 multiplier (three passes)
//  and, unless it adds nothing or saturates, one shared restoring divider
//  (15 steps); the mean takes SW divider steps.
//  Reset is asynchronous, active low; both stores are undefined until loaded.
//  A waiting result does not stall loads; a new result waits for the slot.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_template_match_search #(
  parameter int MAX_WIDTH  = gtms_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gtms_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_POINTS = gtms_pkg::MAX_POINTS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pixel_x, pixel_y, point_index, point_off_x, point_off_y, grad_x, grad_y,
  // grad_mag, search_x, search_y (from bit 0 up)
  input  wire logic [gtms_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // mode
  input  wire logic [1:0]                       s_axis_tuser,
  // result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // best_x, best_y, best_score (from bit 0 up)
  output logic [gtms_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // found
  output logic                                  m_axis_tuser,
  // configuration writes
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [gtms_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [gtms_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int DIM_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIMB    = $clog2(DIM_MAX);
  localparam int CW      = ((DIMB > 10) ? DIMB : 10) + 2;
  localparam int IDEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(IDEPTH);
  localparam int TW      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int PCW     = $clog2(MAX_POINTS + 1);
  localparam int SW      = PCW + 15;
  localparam int DCW     = $clog2(SW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_TRD, S_PT, S_IWT, S_M0, S_M1, S_M2,
    S_DCHK, S_DIV, S_ACC, S_CMP, S_OUT
  } state_e;

  // ---------------- input field unpacking
  logic [8:0]  in_px, in_py, in_sx, in_sy;
  logic [9:0]  in_idx;
  logic [7:0]  in_offx, in_offy;
  logic [15:0] in_gx, in_gy, in_mag;

  assign in_px   = s_axis_tdata[8:0];
  assign in_py   = s_axis_tdata[17:9];
  assign in_idx  = s_axis_tdata[27:18];
  assign in_offx = s_axis_tdata[35:28];
  assign in_offy = s_axis_tdata[43:36];
  assign in_gx   = s_axis_tdata[59:44];
  assign in_gy   = s_axis_tdata[75:60];
  assign in_mag  = s_axis_tdata[91:76];
  assign in_sx   = s_axis_tdata[100:92];
  assign in_sy   = s_axis_tdata[109:101];

  // ---------------- configuration registers
  logic [9:0]  img_w_q, img_h_q;
  logic [6:0]  step_q;
  logic [8:0]  rad_q;
  logic [10:0] pcount_q;
  logic [15:0] thr_cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q   <= 10'd512;
      img_h_q   <= 10'd512;
      step_q    <= 7'd1;
      rad_q     <= 9'd16;
      pcount_q  <= 11'd0;
      thr_cfg_q <= 16'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gtms_pkg::CFG_IMAGE_WIDTH:  img_w_q   <= cfg_data_i[9:0];
        gtms_pkg::CFG_IMAGE_HEIGHT: img_h_q   <= cfg_data_i[9:0];
        gtms_pkg::CFG_SEARCH_STEP:  step_q    <= cfg_data_i[6:0];
        gtms_pkg::CFG_SEARCH_RAD:   rad_q     <= cfg_data_i[8:0];
        gtms_pkg::CFG_POINT_COUNT:  pcount_q  <= cfg_data_i[10:0];
        gtms_pkg::CFG_THRESHOLD:    thr_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- effective limits
  logic [CW-1:0]  w_eff, h_eff, step_eff;
  logic [PCW-1:0] cnt_eff;

  always_comb begin
    if (img_w_q == 10'd0) w_eff = CW'(1);
    else if (32'(img_w_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(img_w_q);
    if (img_h_q == 10'd0) h_eff = CW'(1);
    else if (32'(img_h_q) > MAX_HEIGHT) h_eff = CW'(MAX_HEIGHT);
    else h_eff = CW'(img_h_q);
    step_eff = (step_q == 7'd0) ? CW'(1) : CW'(step_q);
    if (32'(pcount_q) > MAX_POINTS) cnt_eff = PCW'(MAX_POINTS);
    else cnt_eff = PCW'(pcount_q);
  end

  // ---------------- sequencer registers
  state_e         state_q;
  logic [8:0]     sx_q, sy_q;
  logic [CW-1:0]  x0_q, x1_q, y1_q, cx_q, cy_q;
  logic [PCW-1:0] k_q;
  logic [AW-1:0]  iaddr_q;
  logic signed [33:0] dot_q;
  logic [31:0]    den_q, rem_q;
  logic [SW-1:0]  dvd_q, sum_q;
  logic [15:0]    quo_q, term_q, thr_q;
  logic [DCW-1:0] dcnt_q;
  logic           div_mean_q;
  logic           found_q;
  logic [8:0]     bx_q, by_q;
  logic [15:0]    bs_q;
  logic           m_valid_q;
  logic [gtms_pkg::OUT_TDATA_W-1:0] m_data_q;
  logic           m_found_q;
  logic           out_load;

  // result slot is loaded when free or being emptied
  assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

  // ---------------- memories
  logic [47:0] img_rdata;
  logic [63:0] tpl_rdata;
  logic        s_fire;
  logic        img_we, tpl_we;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign img_we = s_fire && (s_axis_tuser == gtms_pkg::MODE_PIXEL)
                  && (32'(in_px) < MAX_WIDTH) && (32'(in_py) < MAX_HEIGHT);
  assign tpl_we = s_fire && (s_axis_tuser == gtms_pkg::MODE_POINT)
                  && (32'(in_idx) < MAX_POINTS);

  gtms_ram #(.WIDTH(48), .DEPTH(IDEPTH)) u_img_ram (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i (AW'(32'(in_py) * MAX_WIDTH + 32'(in_px))),
    .wdata_i ({in_mag, in_gy, in_gx}),
    .raddr_i (iaddr_q),
    .rdata_o (img_rdata)
  );

  gtms_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_tpl_ram (
    .clk_i   (clk_i),
    .we_i    (tpl_we),
    .waddr_i (TW'(in_idx)),
    .wdata_i ({in_mag, in_gy, in_gx, in_offy, in_offx}),
    .raddr_i (k_q[TW-1:0]),
    .rdata_o (tpl_rdata)
  );

  logic [7:0]  t_offx, t_offy;
  logic [15:0] t_gx, t_gy, t_mag, i_gx, i_gy, i_mag;
  assign t_offx = tpl_rdata[7:0];
  assign t_offy = tpl_rdata[15:8];
  assign t_gx   = tpl_rdata[31:16];
  assign t_gy   = tpl_rdata[47:32];
  assign t_mag  = tpl_rdata[63:48];
  assign i_gx   = img_rdata[15:0];
  assign i_gy   = img_rdata[31:16];
  assign i_mag  = img_rdata[47:32];

  // ---------------- shared multiplier
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;

  always_comb begin
    unique case (state_q)
      S_M0: begin
        mul_a = {t_gx[15], t_gx};
        mul_b = {i_gx[15], i_gx};
      end
      S_M1: begin
        mul_a = {t_gy[15], t_gy};
        mul_b = {i_gy[15], i_gy};
      end
      default: begin
        mul_a = {1'b0, t_mag};
        mul_b = {1'b0, i_mag};
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // ---------------- shared divider step
  logic [32:0] div_r2, div_diff;
  logic        div_ge;
  assign div_r2   = {rem_q, dvd_q[SW-1]};
  assign div_diff = div_r2 - {1'b0, den_q};
  assign div_ge   = (div_r2 >= {1'b0, den_q});

  // ---------------- window setup and point address arithmetic
  logic signed [CW:0] lo_x, lo_y;
  logic [CW-1:0]      hi_x, hi_y, wm1, hm1, px, py, nx, ny;
  logic [31:0]        abs_dot;

  always_comb begin
    wm1  = w_eff - CW'(1);
    hm1  = h_eff - CW'(1);
    lo_x = $signed({1'b0, CW'(sx_q)}) - $signed({1'b0, CW'(rad_q)});
    lo_y = $signed({1'b0, CW'(sy_q)}) - $signed({1'b0, CW'(rad_q)});
    hi_x = CW'(sx_q) + CW'(rad_q);
    hi_y = CW'(sy_q) + CW'(rad_q);
    px   = cx_q + CW'(t_offx);
    py   = cy_q + CW'(t_offy);
    nx   = cx_q + step_eff;
    ny   = cy_q + step_eff;
    abs_dot = dot_q[33] ? 32'(-dot_q) : 32'(dot_q);
  end

  // ---------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      m_valid_q  <= 1'b0;
      div_mean_q <= 1'b0;
      found_q    <= 1'b0;
      k_q        <= '0;
      iaddr_q    <= '0;
      dcnt_q     <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && !out_load) m_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_fire && (s_axis_tuser == gtms_pkg::MODE_SEARCH)) begin
            sx_q    <= in_sx;
            sy_q    <= in_sy;
            state_q <= S_SETUP;
          end
        end
        S_SETUP: begin
          // clamp the window to the image
          if (lo_x[CW]) x0_q <= '0;
          else if (lo_x[CW-1:0] > wm1) x0_q <= wm1;
          else x0_q <= lo_x[CW-1:0];
          if (lo_y[CW]) cy_q <= '0;
          else if (lo_y[CW-1:0] > hm1) cy_q <= hm1;
          else cy_q <= lo_y[CW-1:0];
          if (lo_x[CW]) cx_q <= '0;
          else if (lo_x[CW-1:0] > wm1) cx_q <= wm1;
          else cx_q <= lo_x[CW-1:0];
          x1_q    <= (hi_x > wm1) ? wm1 : hi_x;
          y1_q    <= (hi_y > hm1) ? hm1 : hi_y;
          thr_q   <= thr_cfg_q;
          found_q <= 1'b0;
          bx_q    <= '0;
          by_q    <= '0;
          bs_q    <= '0;
          k_q     <= '0;
          sum_q   <= '0;
          state_q <= (cnt_eff == '0) ? S_OUT : S_TRD;
        end
        S_TRD: begin
          state_q <= S_PT;
        end
        S_PT: begin
          // template point valid; skip points off the image or without edge
          if ((px < w_eff) && (py < h_eff) && (t_mag != 16'd0)) begin
            iaddr_q <= AW'(32'(py) * MAX_WIDTH + 32'(px));
            state_q <= S_IWT;
          end else begin
            term_q  <= '0;
            state_q <= S_ACC;
          end
        end
        S_IWT: begin
          state_q <= S_M0;
        end
        S_M0: begin
          dot_q   <= mul_p;
          state_q <= S_M1;
        end
        S_M1: begin
          dot_q   <= dot_q + mul_p;
          state_q <= S_M2;
        end
        S_M2: begin
          den_q   <= mul_p[31:0];
          state_q <= S_DCHK;
        end
        S_DCHK: begin
          // zero image magnitude adds nothing; ratio of one or more saturates
          if (den_q == 32'd0) begin
            term_q  <= '0;
            state_q <= S_ACC;
          end else if (abs_dot >= den_q) begin
            term_q  <= gtms_pkg::Q_ONE;
            state_q <= S_ACC;
          end else begin
            rem_q      <= abs_dot;
            dvd_q      <= '0;
            quo_q      <= '0;
            dcnt_q     <= DCW'(15);
            div_mean_q <= 1'b0;
            state_q    <= S_DIV;
          end
        end
        S_DIV: begin
          // one restoring step per cycle
          rem_q  <= div_ge ? div_diff[31:0] : div_r2[31:0];
          quo_q  <= {quo_q[14:0], div_ge};
          dvd_q  <= {dvd_q[SW-2:0], 1'b0};
          dcnt_q <= dcnt_q - DCW'(1);
          if (dcnt_q == DCW'(1)) begin
            if (div_mean_q) begin
              state_q <= S_CMP;
            end else begin
              term_q  <= {quo_q[14:0], div_ge};
              state_q <= S_ACC;
            end
          end
        end
        S_ACC: begin
          if (k_q == cnt_eff - PCW'(1)) begin
            rem_q      <= '0;
            dvd_q      <= sum_q + SW'(term_q);
            den_q      <= 32'(cnt_eff);
            quo_q      <= '0;
            dcnt_q     <= DCW'(SW);
            div_mean_q <= 1'b1;
            state_q    <= S_DIV;
          end else begin
            sum_q   <= sum_q + SW'(term_q);
            k_q     <= k_q + PCW'(1);
            state_q <= S_TRD;
          end
        end
        S_CMP: begin
          // strictly greater mean wins, so the first of equal maxima stays
          if (quo_q > thr_q) begin
            found_q <= 1'b1;
            thr_q   <= quo_q;
            bx_q    <= cx_q[8:0];
            by_q    <= cy_q[8:0];
            bs_q    <= quo_q;
          end
          k_q   <= '0;
          sum_q <= '0;
          if (nx <= x1_q) begin
            cx_q    <= nx;
            state_q <= S_TRD;
          end else if (ny <= y1_q) begin
            cx_q    <= x0_q;
            cy_q    <= ny;
            state_q <= S_TRD;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q  <= {6'd0, bs_q, by_q, bx_q};
      m_found_q <= found_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_found_q;

endmodule

`default_nettype wire

// File: rtl/core/gtms_checker.sv
// ----------------------------------------------------------------------------
// gtms_checker
// Port level checks for the gradient template match search block.
// ----------------------------------------------------------------------------
`default_nettype none

module gtms_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [1:0]                      s_axis_tuser,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [gtms_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                            m_axis_tuser
);

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // loads never block the next transfer
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser != gtms_pkg::MODE_SEARCH) |=> s_axis_tready)
    else $error("not ready after a load");

  // a search occupies the block
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser == gtms_pkg::MODE_SEARCH) |=> !s_axis_tready)
    else $error("ready straight after a search");

  // no match reports all zero fields
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("fields set without a match");

  // a match beats a threshold of at least zero
  a_hit_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[33:18] != 16'd0)
    else $error("match with zero score");

endmodule

bind gradient_template_match_search gtms_checker u_gtms_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream testbench for gradient_template_match_search: loads gradient pixels
// and template points, runs window searches under varied register settings
// and checks every result against a local scoring predictor or a directed expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLD_CYCLES    = 2000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  px;
    logic [8:0]  py;
    logic [9:0]  pidx;
    logic [7:0]  offx;
    logic [7:0]  offy;
    logic [15:0] gx;
    logic [15:0] gy;
    logic [15:0] mag;
    logic [8:0]  sx;
    logic [8:0]  sy;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  typedef struct packed {
    logic        found;
    logic [8:0]  bx;
    logic [8:0]  by;
    logic [15:0] score;
  } match_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    item_t       it;
    logic [2:0]  idx;
    logic [15:0] val;
    bit          typed;
    match_t      res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [gtms_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [gtms_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [gtms_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [gtms_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  gradient_template_match_search i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Predictor state
  logic [47:0] img_mem [gtms_pkg::MAX_WIDTH_DEF*gtms_pkg::MAX_HEIGHT_DEF];
  logic [63:0] tmpl_mem [gtms_pkg::MAX_POINTS_DEF];
  int unsigned reg_w = 512, reg_h = 512, reg_step = 1, reg_rad = 16;
  int unsigned reg_cnt = 0, reg_thr = 0;

  match_t pending_q[$];
  int errors = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int idle_cnt = 0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // One point's normalised score, saturated at unity
  function automatic int unsigned match_term(logic [63:0] p, logic [47:0] q);
    longint dot, a;
    longint unsigned den, t;
    dot = longint'($signed(p[31:16])) * longint'($signed(q[15:0]))
        + longint'($signed(p[47:32])) * longint'($signed(q[31:16]));
    a = dot < 0 ? -dot : dot;
    den = longint'(p[63:48]) * longint'(q[47:32]);
    if (den == 0) return 0;
    t = (longint'(a) << 15) / den;
    return t > 32768 ? 32768 : int'(t);
  endfunction

  function automatic int clampc(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Best candidate over the clamped window
  function automatic match_t search_predict(int sx, int sy);
    match_t r;
    int w, h, st, x0, x1, y0, y1, px, py;
    int unsigned cnt, thr, sum, mean;
    w = reg_w == 0 ? 1 : (reg_w > 512 ? 512 : reg_w);
    h = reg_h == 0 ? 1 : (reg_h > 512 ? 512 : reg_h);
    st = reg_step == 0 ? 1 : reg_step;
    cnt = reg_cnt > 1024 ? 1024 : reg_cnt;
    x0 = clampc(sx - int'(reg_rad), w - 1); x1 = clampc(sx + int'(reg_rad), w - 1);
    y0 = clampc(sy - int'(reg_rad), h - 1); y1 = clampc(sy + int'(reg_rad), h - 1);
    thr = reg_thr;
    r = '0;
    if (cnt != 0) begin
      for (int cy = y0; cy <= y1; cy += st) begin
        for (int cx = x0; cx <= x1; cx += st) begin
          sum = 0;
          for (int k = 0; k < cnt; k++) begin
            px = cx + int'(tmpl_mem[k][7:0]);
            py = cy + int'(tmpl_mem[k][15:8]);
            if (px < w && py < h) sum += match_term(tmpl_mem[k], img_mem[py*512 + px]);
          end
          mean = sum / cnt;
          if (mean > thr) begin
            thr = mean;
            r.found = 1'b1; r.bx = 9'(cx); r.by = 9'(cy); r.score = 16'(mean);
          end
        end
      end
    end
    return r;
  endfunction

  function automatic void apply_item(item_t it, bit typed, match_t tres);
    case (it.mode)
      gtms_pkg::MODE_PIXEL:  img_mem[it.py*512 + it.px] = {it.mag, it.gy, it.gx};
      gtms_pkg::MODE_POINT:  tmpl_mem[it.pidx] = {it.mag, it.gy, it.gx, it.offy, it.offx};
      gtms_pkg::MODE_SEARCH: pending_q.push_back(typed ? tres : search_predict(it.sx, it.sy));
      default: ;
    endcase
  endfunction

  // Sender: gap, offer, wait for the transfer
  task automatic send_item(input item_t it, input bit typed = 0, input match_t tres = '0);
    int gap;
    gap = no_idle ? 0 : $urandom_range(4, 0);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata = {2'b0, it.sy, it.sx, it.mag, it.gy, it.gx, it.offy, it.offx,
                    it.pidx, it.py, it.px};
    s_axis_tuser = it.mode;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_item(it, typed, tres);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Wait for all results, then let in-flight loads settle
  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_index_i = idx;
    cfg_data_i = val;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      gtms_pkg::CFG_IMAGE_WIDTH:  reg_w = val & 16'h3FF;
      gtms_pkg::CFG_IMAGE_HEIGHT: reg_h = val & 16'h3FF;
      gtms_pkg::CFG_SEARCH_STEP:  reg_step = val & 16'h7F;
      gtms_pkg::CFG_SEARCH_RAD:   reg_rad = val & 16'h1FF;
      gtms_pkg::CFG_POINT_COUNT:  reg_cnt = val & 16'h7FF;
      gtms_pkg::CFG_THRESHOLD:    reg_thr = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic item_t rand_item(logic [1:0] mode);
    item_t it;
    it = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
    it.mode = mode;
    return it;
  endfunction

  function automatic row_t cfg_row(logic [2:0] idx, logic [15:0] val);
    row_t r;
    r = '{kind: ROW_CFG, it: '0, idx: idx, val: val, typed: 0, res: '0};
    return r;
  endfunction

  function automatic row_t item_row(item_t it, bit typed = 0, match_t res = '0);
    row_t r;
    r = '{kind: ROW_ITEM, it: it, idx: '0, val: '0, typed: typed, res: res};
    return r;
  endfunction

  function automatic item_t search_at(int sx, int sy);
    item_t it;
    it = rand_item(gtms_pkg::MODE_SEARCH);
    it.sx = 9'(sx); it.sy = 9'(sy);
    return it;
  endfunction

  function automatic item_t grad_item(logic [1:0] mode, int x, int y, int k, int ox, int oy,
                                      int gx, int gy, int mag);
    item_t it;
    it = rand_item(mode);
    it.px = 9'(x); it.py = 9'(y); it.pidx = 10'(k); it.offx = 8'(ox); it.offy = 8'(oy);
    it.gx = 16'(gx); it.gy = 16'(gy); it.mag = 16'(mag);
    return it;
  endfunction

  // Result checker with random back-pressure and one long hold-off
  initial begin : rx_proc
    int gap;
    match_t want;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      gap = no_idle ? 0 : $urandom_range(4, 0);
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (pending_q.size() == 0) begin
        report("unexpected result", m_axis_tuser, 0);
      end else begin
        want = pending_q.pop_front();
        if (m_axis_tuser !== want.found) report("found", m_axis_tuser, want.found);
        if (m_axis_tdata[8:0] !== want.bx) report("best_x", m_axis_tdata[8:0], want.bx);
        if (m_axis_tdata[17:9] !== want.by) report("best_y", m_axis_tdata[17:9], want.by);
        if (m_axis_tdata[33:18] !== want.score)
          report("best_score", m_axis_tdata[33:18], want.score);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("[gradient_template_match_search] ERROR");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin : tx_proc
    row_t tbl[$];
    item_t it;
    int kind;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Fill a 16x16 corner of the image and the first 16 points (small offsets)
    no_idle = 1'b1;
    for (int y = 0; y < 16; y++)
      for (int x = 0; x < 16; x++) begin
        it = rand_item(gtms_pkg::MODE_PIXEL); it.px = 9'(x); it.py = 9'(y);
        send_item(it);
      end
    for (int k = 0; k < 16; k++) begin
      it = rand_item(gtms_pkg::MODE_POINT); it.pidx = 10'(k);
      it.offx = 8'($urandom_range(15, 0)); it.offy = 8'($urandom_range(15, 0));
      send_item(it);
    end
    no_idle = 1'b0;

    // Directed table
    tbl.push_back(item_row(search_at(5, 5), 1, '0));        // point count zero
    tbl.push_back(cfg_row(gtms_pkg::CFG_IMAGE_WIDTH, 16));
    tbl.push_back(cfg_row(gtms_pkg::CFG_IMAGE_HEIGHT, 16));
    tbl.push_back(cfg_row(gtms_pkg::CFG_POINT_COUNT, 16));
    tbl.push_back(item_row(search_at(8, 8)));
    tbl.push_back(item_row(search_at(511, 511)));            // centre off the image
    tbl.push_back(item_row(search_at(0, 0)));
    tbl.push_back(cfg_row(gtms_pkg::CFG_THRESHOLD, 16'h8000));
    tbl.push_back(item_row(search_at(7, 3), 1, '0));         // nothing beats unity
    tbl.push_back(cfg_row(gtms_pkg::CFG_THRESHOLD, 0));
    tbl.push_back(cfg_row(gtms_pkg::CFG_SEARCH_STEP, 0));
    tbl.push_back(item_row(search_at(2, 9)));
    tbl.push_back(cfg_row(gtms_pkg::CFG_SEARCH_STEP, 127));
    tbl.push_back(item_row(search_at(9, 2)));
    tbl.push_back(cfg_row(gtms_pkg::CFG_SEARCH_RAD, 511));
    tbl.push_back(cfg_row(gtms_pkg::CFG_SEARCH_STEP, 64));
    tbl.push_back(item_row(search_at(300, 40)));
    tbl.push_back(cfg_row(gtms_pkg::CFG_SEARCH_STEP, 1));
    tbl.push_back(item_row(search_at(0, 511)));              // whole 16x16 image
    tbl.push_back(cfg_row(gtms_pkg::CFG_SEARCH_RAD, 0));
    tbl.push_back(cfg_row(gtms_pkg::CFG_IMAGE_WIDTH, 0));    // zero sizes act as 1
    tbl.push_back(cfg_row(gtms_pkg::CFG_IMAGE_HEIGHT, 0));
    tbl.push_back(item_row(search_at(3, 3)));
    tbl.push_back(cfg_row(gtms_pkg::CFG_IMAGE_WIDTH, 1023)); // saturates to full width
    tbl.push_back(cfg_row(gtms_pkg::CFG_IMAGE_HEIGHT, 1));
    tbl.push_back(item_row(search_at(0, 0)));
    tbl.push_back(cfg_row(gtms_pkg::CFG_IMAGE_WIDTH, 1));
    tbl.push_back(cfg_row(gtms_pkg::CFG_IMAGE_HEIGHT, 512));
    tbl.push_back(item_row(search_at(0, 0)));
    tbl.push_back(cfg_row(gtms_pkg::CFG_IMAGE_WIDTH, 16));
    tbl.push_back(cfg_row(gtms_pkg::CFG_IMAGE_HEIGHT, 16));
    tbl.push_back(cfg_row(gtms_pkg::CFG_SEARCH_RAD, 2));
    tbl.push_back(item_row(grad_item(gtms_pkg::MODE_PIXEL, 511, 511, 0, 0, 0,
                                     -32768, 32767, 65535)));
    tbl.push_back(item_row(grad_item(gtms_pkg::MODE_PIXEL, 0, 0, 0, 0, 0, 32767, -32768, 0)));
    tbl.push_back(item_row(grad_item(gtms_pkg::MODE_PIXEL, 1, 0, 0, 0, 0, 1, 1, 1)));  // saturating
    tbl.push_back(item_row(grad_item(gtms_pkg::MODE_POINT, 0, 0, 1023, 255, 255,
                                     -32768, -32768, 65535)));
    tbl.push_back(item_row(grad_item(gtms_pkg::MODE_POINT, 0, 0, 0, 0, 0, 32767, 32767, 0)));
    tbl.push_back(item_row(grad_item(gtms_pkg::MODE_POINT, 0, 0, 1, 1, 0, 32767, 32767, 1)));
    tbl.push_back(item_row(rand_item(MODE_IGNORED)));
    tbl.push_back(item_row(search_at(0, 0)));
    foreach (tbl[i]) begin
      if (tbl[i].kind == ROW_CFG) begin
        drain();
        write_reg(tbl[i].idx, tbl[i].val);
      end else begin
        send_item(tbl[i].it, tbl[i].typed, tbl[i].res);
      end
    end

    // Random rounds
    for (int rnd = 0; rnd < 5; rnd++) begin
      drain();
      no_idle = (rnd % 5 == 3);
      write_reg(gtms_pkg::CFG_IMAGE_WIDTH, 16'($urandom_range(16, 0)));
      write_reg(gtms_pkg::CFG_IMAGE_HEIGHT, 16'($urandom_range(16, 0)));
      write_reg(gtms_pkg::CFG_SEARCH_STEP, $urandom_range(9) == 0 ? 16'($urandom_range(127, 5))
                                                                   : 16'($urandom_range(3, 0)));
      write_reg(gtms_pkg::CFG_SEARCH_RAD, 16'($urandom_range(2, 0)));
      write_reg(gtms_pkg::CFG_POINT_COUNT, 16'($urandom_range(8, 0)));
      write_reg(gtms_pkg::CFG_THRESHOLD, $urandom_range(9) == 0 ? 16'h8000
                                                                 : 16'($urandom_range(20000, 0)));
      if (rnd == 2) begin
        // searches pile up behind a stalled receiver
        hold_req = 1'b1;
        for (int i = 0; i < 6; i++) send_item(search_at($urandom_range(511, 0),
                                                        $urandom_range(511, 0)));
      end
      for (int i = 0; i < 28; i++) begin
        kind = $urandom_range(99, 0);
        if (kind < 40) begin
          it = rand_item(gtms_pkg::MODE_PIXEL);
          if ($urandom_range(9) < 7) begin
            it.px = 9'($urandom_range(15, 0)); it.py = 9'($urandom_range(15, 0));
          end
        end else if (kind < 70) begin
          it = rand_item(gtms_pkg::MODE_POINT);
          if ($urandom_range(9) < 7) begin
            it.pidx = 10'($urandom_range(15, 0));
            it.offx = 8'($urandom_range(15, 0)); it.offy = 8'($urandom_range(15, 0));
          end
        end else if (kind < 95) begin
          it = rand_item(gtms_pkg::MODE_SEARCH);
          if ($urandom_range(1)) begin
            it.sx = 9'($urandom_range(15, 0)); it.sy = 9'($urandom_range(15, 0));
          end
        end else begin
          it = rand_item(MODE_IGNORED);
        end
        send_item(it);
      end
    end

    // Full template with a saturating point count
    drain();
    for (int k = 0; k < 1024; k++) begin
      it = rand_item(gtms_pkg::MODE_POINT); it.pidx = 10'(k);
      it.offx = 8'($urandom_range(20, 0)); it.offy = 8'($urandom_range(20, 0));
      send_item(it);
    end
    drain();
    write_reg(gtms_pkg::CFG_IMAGE_WIDTH, 16);
    write_reg(gtms_pkg::CFG_IMAGE_HEIGHT, 16);
    write_reg(gtms_pkg::CFG_SEARCH_RAD, 0);
    write_reg(gtms_pkg::CFG_THRESHOLD, 0);
    write_reg(gtms_pkg::CFG_POINT_COUNT, 2047);
    send_item(search_at(0, 0));
    send_item(search_at(3, 1));

    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("[gradient_template_match_search] OK");
    end else begin
      $display("[gradient_template_match_search] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
